// ===== hw/rtl/salseq_pkg.sv =====
// shared constants for the staged alarm light sequencer
// used by salseq_rcos_rom, salseq_serial_div and staged_alarm_light_sequencer
// no dependencies
package salseq_pkg;

  // field widths
  localparam int NOW_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int LEVEL_W    = 8;
  localparam int MASK_W     = 3;
  localparam int IV_W       = 20;
  localparam int PERIOD_W   = 16;
  localparam int FLASH_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // parameter defaults
  localparam int DEF_PHASE_TABLE_DEPTH = 1024;
  localparam int DEF_TIME_WIDTH        = 32;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OFF    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_IV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_IV    = 2'd3;

  // configuration reset values
  localparam logic [IV_W-1:0]     RST_STAGE_IV    = 20'd60000;
  localparam logic [PERIOD_W-1:0] RST_SLOW_PERIOD = 16'd6000;
  localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD = 16'd3000;
  localparam logic [FLASH_W-1:0]  RST_FLASH_IV    = 16'd1000;

  // write masks
  localparam logic [MASK_W-1:0] MASK_NONE = 3'b000;
  localparam logic [MASK_W-1:0] MASK_ONE  = 3'b001;
  localparam logic [MASK_W-1:0] MASK_TWO  = 3'b011;
  localparam logic [MASK_W-1:0] MASK_ALL  = 3'b111;

  // stage numbering
  localparam logic [2:0] STAGE_FIRST  = 3'd1;
  localparam logic [2:0] STAGE_SECOND = 3'd2;
  localparam logic [2:0] STAGE_FAST   = 3'd4;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;

endpackage

// ===== hw/rtl/salseq_rcos_rom.sv =====
// raised-cosine brightness table with registered read
// contents filled at start-up from a fixed-point sine; depends on salseq_pkg
module salseq_rcos_rom
  import salseq_pkg::*;
#(
  parameter int Depth = DEF_PHASE_TABLE_DEPTH,
  parameter int AddrW = $clog2(DEF_PHASE_TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic [AddrW-1:0]   addr,
  output logic [LEVEL_W-1:0] data
);

  localparam logic [63:0] Q_ONE  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  logic [LEVEL_W-1:0] rom_table [Depth];

  // floor(255 * sin^2(pi*i/Depth)) via degree-13 taylor sine in q30
  function automatic logic [LEVEL_W-1:0] calc_entry(input int unsigned idx);
    logic [63:0] t, x, x2, r, s, s2, b;
    t = 64'(idx);
    if (2 * t > 64'(Depth)) t = 64'(Depth) - t;
    x  = (PI_Q30 * t) / Depth;
    x2 = (x * x) >> 30;
    r  = Q_ONE;
    // horner form, divisors 13*12 down to 3*2
    for (int k = 0; k < 6; k++) begin
      r = Q_ONE - ((x2 * r) >> 30) / 64'((13 - 2 * k) * (12 - 2 * k));
    end
    s = (x * r) >> 30;
    if (s > Q_ONE) s = Q_ONE;
    s2 = (s * s) >> 30;
    b  = (64'd255 * s2 + 64'd1024) >> 30;
    if (b > 64'd255) b = 64'd255;
    return b[LEVEL_W-1:0];
  endfunction

  initial begin
    for (int i = 0; i < Depth; i++) begin
      rom_table[i] = calc_entry(i);
    end
  end

  always_ff @(posedge clk) begin
    data <= rom_table[addr];
  end

endmodule

// ===== hw/rtl/salseq_serial_div.sv =====
// bit-serial restoring divider: now mod period, then phase index
// idx = ((dividend mod p) * Depth) / p, one quotient bit per cycle; depends on salseq_pkg
module salseq_serial_div
  import salseq_pkg::*;
#(
  parameter int Depth     = DEF_PHASE_TABLE_DEPTH,
  parameter int TimeWidth = DEF_TIME_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [TimeWidth-1:0]         dividend,
  input  logic [PERIOD_W-1:0]          divisor,
  output logic                         done,
  output logic [$clog2(Depth)-1:0]     idx
);

  localparam int QB    = $clog2(Depth);
  localparam int SW    = (TimeWidth > QB) ? TimeWidth : QB;
  localparam int CNT_W = $clog2(SW);
  localparam int PW    = PERIOD_W;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MOD  = 4'b0010,
    D_MUL  = 4'b0100,
    D_IDX  = 4'b1000
  } div_state_t;

  div_state_t       state;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    divisor_r;
  logic [SW-1:0]    sh;
  logic [QB-1:0]    q;
  logic [CNT_W-1:0] cnt;

  logic [PW:0]      trial;
  logic             ge;
  logic [PW-1:0]    rem_step;
  logic [PW+QB-1:0] prod;

  // one restoring step: bring in the next bit, subtract if it fits
  assign trial    = {rem, sh[SW-1]};
  assign ge       = trial >= {1'b0, divisor_r};
  assign rem_step = ge ? PW'(trial - {1'b0, divisor_r}) : trial[PW-1:0];
  assign prod     = (PW+QB)'(rem) * (PW+QB)'(Depth);

  assign idx = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            rem       <= '0;
            sh        <= SW'(dividend) << (SW - TimeWidth);
            divisor_r <= (divisor == '0) ? PW'(1) : divisor;
            cnt       <= CNT_W'(TimeWidth - 1);
            state     <= D_MOD;
          end
        end
        D_MOD: begin
          rem <= rem_step;
          sh  <= sh << 1;
          if (cnt == '0) begin
            state <= D_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        D_MUL: begin
          // quotient fits in QB bits, so the upper part starts below the divisor
          rem   <= prod[PW+QB-1:QB];
          sh    <= SW'(prod[QB-1:0]) << (SW - QB);
          cnt   <= CNT_W'(QB - 1);
          state <= D_IDX;
        end
        D_IDX: begin
          rem <= rem_step;
          sh  <= sh << 1;
          q   <= {q[QB-2:0], ge};
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/staged_alarm_light_sequencer.sv =====
// top level of the staged alarm light sequencer: command decode, stage search,
// flash logic, config registers and output register; depends on salseq_pkg,
// salseq_serial_div and salseq_rcos_rom
//
// usage
//   input channel (in_valid/in_stall, func, now_ms): one command per transfer.
//   output channel (out_valid/out_stall, levels, write_mask): exactly one result
//   per input transfer, in order. a level whose mask bit is clear reads as zero.
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always
//   high; write only while the block is idle.
// sequence per command
//   start, off and unknown commands: straight to the done state, then the output register.
//   update in a fade stage: stage search, then the bit-serial divider, which
//   takes one time bit and then one phase index bit per cycle, then the table
//   read, then the done state and the output register.
//   update in the flash stage: stage search, then the flash state, then done.
//   one item is worked on at a time; in_stall is low only while idle.
// reset clears state, start and flash times, flash flag and config registers
//   to 60000/6000/3000/1000. a stalled result sits in the output register while
//   the next item is taken; that item then waits until the register is free.
module staged_alarm_light_sequencer
  import salseq_pkg::*;
#(
  parameter int PHASE_TABLE_DEPTH = DEF_PHASE_TABLE_DEPTH,
  parameter int TIME_WIDTH        = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [NOW_W-1:0]      now_ms,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    left_level,
  output logic [LEVEL_W-1:0]    top_level,
  output logic [LEVEL_W-1:0]    right_level,
  output logic [MASK_W-1:0]     write_mask,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int AW = $clog2(PHASE_TABLE_DEPTH);
  // stage compare width: thresholds reach four intervals and never wrap
  localparam int CW = (TW > IV_W + 2) ? TW : IV_W + 2;
  localparam int FW = (TW > FLASH_W) ? TW : FLASH_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STAGE = 6'b000010,
    S_DIV   = 6'b000100,
    S_ROM   = 6'b001000,
    S_FLASH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // config registers
  logic [IV_W-1:0]     stage_iv;
  logic [PERIOD_W-1:0] slow_period;
  logic [PERIOD_W-1:0] fast_period;
  logic [FLASH_W-1:0]  flash_iv;

  // sequencer state
  logic [TW-1:0]       start_time;
  logic [TW-1:0]       last_flash_time;
  logic                flash_on;

  // per-item work registers
  logic [TW-1:0]       now_r;
  logic [CW-1:0]       elapsed;
  logic [CW-1:0]       thr;
  logic [2:0]          stage;
  logic [LEVEL_W-1:0]  res_level;
  logic [MASK_W-1:0]   res_mask;

  logic [TW-1:0]       now_t;
  logic [TW-1:0]       elapsed_now;
  logic                in_xfer;
  logic                out_free;
  logic                stage_ge;
  logic [TW-1:0]       flash_diff;
  logic                flash_due;
  logic                div_start;
  logic [PERIOD_W-1:0] div_period;
  logic                div_done;
  logic [AW-1:0]       div_idx;
  logic [LEVEL_W-1:0]  rom_data;
  logic [MASK_W-1:0]   fade_mask;

  assign now_t     = TW'(now_ms);
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // elapsed time since start wraps at the time width
  assign elapsed_now = now_t - start_time;

  // one threshold per cycle; thr walks through iv, 2iv, 3iv, 4iv
  assign stage_ge   = elapsed >= thr;
  assign flash_diff = now_r - last_flash_time;
  assign flash_due  = FW'(flash_diff) >= FW'(flash_iv);

  // leave the stage search with a fade stage: kick off the divider
  assign div_start  = (state == S_STAGE) && !stage_ge;
  assign div_period = (stage == STAGE_FAST) ? fast_period : slow_period;

  always_comb begin
    case (stage)
      STAGE_FIRST:  fade_mask = MASK_ONE;
      STAGE_SECOND: fade_mask = MASK_TWO;
      default:      fade_mask = MASK_ALL;
    endcase
  end

  salseq_serial_div #(
    .Depth     (PHASE_TABLE_DEPTH),
    .TimeWidth (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now_r),
    .divisor  (div_period),
    .done     (div_done),
    .idx      (div_idx)
  );

  // address comes straight from the divider; data is valid the cycle after done
  salseq_rcos_rom #(
    .Depth (PHASE_TABLE_DEPTH),
    .AddrW (AW)
  ) u_rom (
    .clk  (clk),
    .addr (div_idx),
    .data (rom_data)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_iv    <= RST_STAGE_IV;
      slow_period <= RST_SLOW_PERIOD;
      fast_period <= RST_FAST_PERIOD;
      flash_iv    <= RST_FLASH_IV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STAGE_IV:    stage_iv    <= cfg_data[IV_W-1:0];
        REG_SLOW_PERIOD: slow_period <= cfg_data[PERIOD_W-1:0];
        REG_FAST_PERIOD: fast_period <= cfg_data[PERIOD_W-1:0];
        REG_FLASH_IV:    flash_iv    <= cfg_data[FLASH_W-1:0];
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      start_time      <= '0;
      last_flash_time <= '0;
      flash_on        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            now_r     <= now_t;
            res_level <= LEVEL_ZERO;
            res_mask  <= MASK_NONE;
            unique case (func)
              FUNC_UPDATE: begin
                elapsed <= CW'(elapsed_now);
                thr     <= CW'(stage_iv);
                stage   <= STAGE_FIRST;
                state   <= S_STAGE;
              end
              FUNC_START: begin
                start_time      <= now_t;
                last_flash_time <= '0;
                flash_on        <= 1'b0;
                state           <= S_DONE;
              end
              FUNC_OFF: begin
                res_mask <= MASK_ALL;
                state    <= S_DONE;
              end
              default: state <= S_DONE;  // unused code, nothing written
            endcase
          end
        end
        S_STAGE: begin
          if (stage_ge) begin
            stage <= stage + 3'd1;
            thr   <= thr + CW'(stage_iv);
            // past the fourth threshold means the flash stage
            if (stage == STAGE_FAST) state <= S_FLASH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_ROM;
        end
        S_ROM: begin
          res_level <= rom_data;
          res_mask  <= fade_mask;
          state     <= S_DONE;
        end
        S_FLASH: begin
          if (flash_due) begin
            flash_on        <= !flash_on;
            res_level       <= flash_on ? LEVEL_ZERO : LEVEL_FULL;
            res_mask        <= MASK_ALL;
            last_flash_time <= now_r;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: loaded from S_DONE when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      left_level  <= res_mask[0] ? res_level : LEVEL_ZERO;
      top_level   <= res_mask[1] ? res_level : LEVEL_ZERO;
      right_level <= res_mask[2] ? res_level : LEVEL_ZERO;
      write_mask  <= res_mask;
    end
  end

endmodule
